// File: rtl/core/lia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lia_pkg
// shared types and constants of the index allocator
// ----------------------------------------------------------------------------
package lia_pkg;
  localparam int unsigned POOL_SIZE = 1024;
  localparam int unsigned LINKS = POOL_SIZE + 2;
  localparam int unsigned LW = $clog2(LINKS);
  localparam int unsigned SW = $clog2(POOL_SIZE);
  localparam int unsigned TW = 64;
  localparam logic [LW-1:0] ALLOC_HEAD = LW'(0);
  localparam logic [LW-1:0] FREE_HEAD = LW'(1);
  localparam logic [LW-1:0] SHIFT = LW'(2);
  localparam logic [TW-1:0] EXPIRY_RESET = 64'd1000000000;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_REJUV  = 3'd1,
    OP_FREE   = 3'd2,
    OP_EXPIRE = 3'd3,
    OP_IS     = 3'd4,
    OP_OLDEST = 3'd5
  } op_t;

  typedef struct packed {
    logic [2:0]    op;
    logic [9:0]    slot;
    logic [TW-1:0] now_ns;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [9:0] slot_out;
  } rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/lia_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lia_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface lia_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/lru_index_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_index_allocator_top
// index allocator with free chain and age-ordered allocated chain
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_      in   op, slot, now_ns
//  out_     out  ok, slot_out
//  cfg_     in   expiry_ns
// a request holds the block from its accept until its result is passed on;
// the link walk sets how long: next and prev links sit in two memories with one
// registered read a cycle, and each step waits for the read before it
// after reset a clearing pass over every link builds the free chain; no
// request is taken meanwhile
// the result waits in an output register; a stall there holds the sequencer
// ----------------------------------------------------------------------------
module lru_index_allocator_top (
  input  wire logic clk,
  input  wire logic rst_n,
  lia_if.sink       in_ch,
  lia_if.source     out_ch,
  lia_if.sink       cfg_ch
);
  localparam int unsigned LW = lia_pkg::LW;
  localparam int unsigned SW = lia_pkg::SW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD_E, S_CHK_E, S_RD_ST, S_CHK_ST,
    S_UNL, S_RD_TAIL, S_APP_T, S_APP_E,
    S_FRE, S_FRH, S_RD_A, S_TAKE, S_POP, S_OUT
  } state_t;

  // link memories: next and prev
  logic [LW-1:0]   nmem [lia_pkg::LINKS];
  logic [LW-1:0]   pmem [lia_pkg::LINKS];
  logic [63:0]     smem [lia_pkg::POOL_SIZE];

  state_t          state_r;
  logic [LW-1:0]   addr_r, e_r, p_r, n_r;
  logic [LW-1:0]   rdn_r, rdp_r;
  logic [LW-1:0]   ld_n, ld_p;
  logic [63:0]     srd_r, expiry_r;
  logic [2:0]      op_r;
  logic [63:0]     now_r;
  logic            restamp_r, ok_r, mode_r;
  logic [9:0]      res_r;
  logic            out_ok_r;
  logic [9:0]      out_res_r;
  logic            nwe, pwe;
  logic [LW-1:0]   nwa, pwa, nwd, pwd, ra;
  logic            swe;
  logic [LW-1:0]   init_n;
  logic            in_rng;
  logic [LW-1:0]   in_e;
  logic            full_r;

  assign ld_n = rdn_r;
  assign ld_p = rdp_r;

  function automatic logic [LW-1:0] lk(input logic [LW-1:0] v);
    return (32'(v) < lia_pkg::LINKS) ? v : lia_pkg::ALLOC_HEAD;
  endfunction

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = full_r;
  assign out_ch.data.ok = out_ok_r;
  assign out_ch.data.slot_out = out_res_r;

  assign init_n = (32'(addr_r) + 1 < lia_pkg::LINKS) ? addr_r + LW'(1) : lia_pkg::FREE_HEAD;

  assign in_rng = (32'(in_ch.data.slot) < lia_pkg::POOL_SIZE);
  assign in_e = (in_rng && (in_ch.data.op inside {lia_pkg::OP_REJUV, lia_pkg::OP_FREE,
                                                   lia_pkg::OP_IS}))
                ? LW'(in_ch.data.slot) + lia_pkg::SHIFT : lia_pkg::ALLOC_HEAD;

  // memory write ports
  always_comb begin
    nwe = 1'b0; nwa = addr_r; nwd = '0;
    pwe = 1'b0; pwa = addr_r; pwd = '0;
    swe = 1'b0;
    unique case (state_r)
      S_INIT: begin
        nwe = 1'b1; pwe = 1'b1;
        nwd = (addr_r == lia_pkg::ALLOC_HEAD) ? lia_pkg::ALLOC_HEAD : init_n;
        pwd = (addr_r == lia_pkg::ALLOC_HEAD) ? lia_pkg::ALLOC_HEAD : init_n;
      end
      S_CHK_E: swe = restamp_r && (ld_n == lia_pkg::ALLOC_HEAD) &&
                     (ld_p == lia_pkg::ALLOC_HEAD);
      S_UNL: begin
        nwe = 1'b1; nwa = p_r; nwd = n_r;
        pwe = 1'b1; pwa = n_r; pwd = p_r;
      end
      S_APP_T: begin
        nwe = 1'b1; nwa = lk(ld_p); nwd = e_r;
        pwe = 1'b1; pwa = lia_pkg::ALLOC_HEAD; pwd = e_r;
      end
      S_APP_E: begin
        nwe = 1'b1; nwa = e_r; nwd = lia_pkg::ALLOC_HEAD;
        pwe = 1'b1; pwa = e_r; pwd = p_r;
        swe = restamp_r;
      end
      S_FRE: begin
        nwe = 1'b1; nwa = e_r; nwd = ld_n;
        pwe = 1'b1; pwa = e_r; pwd = ld_n;
      end
      S_FRH: begin
        nwe = 1'b1; nwa = lia_pkg::FREE_HEAD; nwd = e_r;
        pwe = 1'b1; pwa = lia_pkg::FREE_HEAD; pwd = e_r;
      end
      S_POP: begin
        nwe = 1'b1; nwa = lia_pkg::FREE_HEAD; nwd = ld_n;
        pwe = 1'b1; pwa = lia_pkg::FREE_HEAD; pwd = ld_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nwe) nmem[nwa] <= nwd;
    if (pwe) pmem[pwa] <= pwd;
    rdn_r <= nmem[ra];
    rdp_r <= pmem[ra];
    if (swe) smem[SW'(e_r - lia_pkg::SHIFT)] <= now_r;
    srd_r <= smem[SW'(e_r - lia_pkg::SHIFT)];
  end

  // next read address; its data appears in rdn_r and rdp_r in the cycle after
  always_comb begin
    unique case (state_r)
      S_RD_E, S_RD_ST: ra = e_r;
      S_UNL, S_RD_A: ra = lia_pkg::FREE_HEAD;
      S_TAKE: ra = lk(ld_n);
      S_RD_TAIL, S_POP: ra = lia_pkg::ALLOC_HEAD;
      default: ra = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; addr_r <= '0; full_r <= 1'b0;
      expiry_r <= lia_pkg::EXPIRY_RESET;
    end else begin
      if (cfg_ch.valid) expiry_r <= cfg_ch.data;
      if (state_r == S_OUT && (!full_r || out_ch.ready)) begin
        full_r <= 1'b1; out_ok_r <= ok_r; out_res_r <= res_r;
      end else if (out_ch.ready) begin
        full_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          if (32'(addr_r) == lia_pkg::LINKS - 1) state_r <= S_IDLE;
          addr_r <= addr_r + LW'(1);
        end
        S_IDLE: if (in_ch.valid) begin
          op_r <= in_ch.data.op; now_r <= in_ch.data.now_ns;
          ok_r <= 1'b0; res_r <= '0; mode_r <= 1'b0;
          restamp_r <= (in_ch.data.op == lia_pkg::OP_REJUV);
          e_r <= in_e;
          unique case (in_ch.data.op)
            lia_pkg::OP_ALLOC: state_r <= S_RD_A;
            lia_pkg::OP_EXPIRE, lia_pkg::OP_OLDEST: state_r <= S_RD_E;
            lia_pkg::OP_REJUV, lia_pkg::OP_FREE, lia_pkg::OP_IS:
              state_r <= in_rng ? S_RD_E : S_OUT;
            default: state_r <= S_OUT;
          endcase
        end
        S_RD_E: state_r <= S_CHK_E;
        S_CHK_E: begin
          if (op_r == lia_pkg::OP_EXPIRE || op_r == lia_pkg::OP_OLDEST) begin
            if (lk(ld_n) >= lia_pkg::SHIFT) begin
              e_r <= lk(ld_n);
              res_r <= 10'(lk(ld_n) - lia_pkg::SHIFT);
              if (op_r == lia_pkg::OP_OLDEST) begin ok_r <= 1'b1; state_r <= S_OUT; end
              else state_r <= S_RD_ST;
            end else begin
              state_r <= S_OUT;
            end
          end else if (ld_n != ld_p || ld_n == lia_pkg::ALLOC_HEAD) begin
            ok_r <= 1'b1;
            p_r <= lk(ld_p); n_r <= lk(ld_n);
            if (op_r == lia_pkg::OP_IS) state_r <= S_OUT;
            else if (op_r == lia_pkg::OP_FREE) begin mode_r <= 1'b1; state_r <= S_UNL; end
            else if (ld_n != ld_p) state_r <= S_UNL;
            else state_r <= S_OUT;
          end else state_r <= S_OUT;
        end
        S_RD_ST: state_r <= S_CHK_ST;
        S_CHK_ST: begin
          if (now_r >= expiry_r && srd_r < now_r - expiry_r &&
              (ld_n != ld_p || ld_n == lia_pkg::ALLOC_HEAD)) begin
            ok_r <= 1'b1; p_r <= lk(ld_p); n_r <= lk(ld_n); mode_r <= 1'b1;
            state_r <= S_UNL;
          end else begin
            res_r <= '0; state_r <= S_OUT;
          end
        end
        S_UNL: state_r <= mode_r ? S_FRE : S_RD_TAIL;
        S_RD_TAIL: state_r <= S_APP_T;
        S_APP_T: begin p_r <= lk(ld_p); state_r <= S_APP_E; end
        S_APP_E: state_r <= S_OUT;
        S_FRE: state_r <= S_FRH;
        S_FRH: state_r <= S_OUT;
        S_RD_A: state_r <= S_TAKE;
        S_TAKE: begin
          if (lk(ld_n) >= lia_pkg::SHIFT) begin
            e_r <= lk(ld_n);
            ok_r <= 1'b1; res_r <= 10'(lk(ld_n) - lia_pkg::SHIFT);
            restamp_r <= 1'b1;
            state_r <= S_POP;
          end else state_r <= S_OUT;
        end
        S_POP: state_r <= S_APP_T;
        S_OUT: if (!full_r || out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
